>>> rtl/core/lzss_ring_decompressor_assert.svh
// Assertion macros shared by the LZSS ring decompressor RTL.
// No dependencies; included by modules that carry concurrent checks.
`ifndef LZSS_RING_DECOMPRESSOR_ASSERT_SVH
`define LZSS_RING_DECOMPRESSOR_ASSERT_SVH

// expression must hold at every edge outside reset
`define LZRD_ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (expr)) else $error(msg);

// same-cycle implication
`define LZRD_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LZRD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/lzrd_pkg.sv
// Types and constants for the LZSS ring decompressor.
// No dependencies; used by lzrd_ring and lzss_ring_decompressor.
package lzrd_pkg;

    localparam int WINDOW_SIZE = 1024;
    localparam int AW          = $clog2(WINDOW_SIZE);
    localparam int FILL_W      = AW + 1;
    localparam int LEN_W       = 16 - AW;
    localparam int LEFT_W      = LEN_W + 1;

    localparam logic [AW-1:0] FILL_LIMIT = AW'(10'h3C0);
    localparam logic [7:0]    FILL_BYTE  = 8'h20;
    localparam logic [3:0]    FLAG_TOKENS = 4'd8;

    typedef struct packed {
        logic          rd_en;
        logic [AW-1:0] rd_addr;
        logic          wr_en;
        logic [7:0]    wr_data;
    } t_ring_req;

endpackage

>>> rtl/core/lzrd_ring.sv
// History ring: 1 KiB synchronous memory with write pointer, fill count
// and same-cycle write forwarding. Depends on lzrd_pkg and the assert header.
`include "lzss_ring_decompressor_assert.svh"

module lzrd_ring (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  lzrd_pkg::t_ring_req   i_req,
    output logic [7:0]            o_rd_value
);

    logic [7:0] r_mem [lzrd_pkg::WINDOW_SIZE];

    logic [lzrd_pkg::AW-1:0]     r_wp;
    logic [lzrd_pkg::FILL_W-1:0] r_fill;
    logic [lzrd_pkg::FILL_W-1:0] n_fill;

    logic [7:0] r_rd_data;
    logic [7:0] r_fwd_data;
    logic       r_hit;
    logic       r_written;
    logic       r_low;

    logic [lzrd_pkg::AW-1:0] rd_dist;

    // entries never written since reset read as FILL_BYTE below FILL_LIMIT and as zero above it
    always_comb begin
        if (r_fill == lzrd_pkg::FILL_W'(lzrd_pkg::WINDOW_SIZE)) begin
            n_fill = r_fill;
        end else begin
            n_fill = r_fill + lzrd_pkg::FILL_W'(i_req.wr_en);
        end
        rd_dist = i_req.rd_addr - lzrd_pkg::FILL_LIMIT;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= lzrd_pkg::FILL_LIMIT;
            r_fill <= '0;
        end else begin
            r_fill <= n_fill;
            if (i_req.wr_en) begin
                r_wp <= r_wp + lzrd_pkg::AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[r_wp] <= i_req.wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_rd_data  <= r_mem[i_req.rd_addr];
            r_fwd_data <= i_req.wr_data;
            r_hit      <= i_req.wr_en && (r_wp == i_req.rd_addr);
            r_written  <= {1'b0, rd_dist} < n_fill;
            r_low      <= i_req.rd_addr < lzrd_pkg::FILL_LIMIT;
        end
    end

    always_comb begin
        if (r_hit) begin
            o_rd_value = r_fwd_data;
        end else if (r_written) begin
            o_rd_value = r_rd_data;
        end else if (r_low) begin
            o_rd_value = lzrd_pkg::FILL_BYTE;
        end else begin
            o_rd_value = 8'h00;
        end
    end

    `LZRD_ASSERT_ALWAYS(a_fill_max, i_clk, i_rst_n,
        r_fill <= lzrd_pkg::FILL_W'(lzrd_pkg::WINDOW_SIZE), "ring fill count overran")
    `LZRD_ASSERT_NEXT(a_fill_step, i_clk, i_rst_n,
        i_req.wr_en && (r_fill < lzrd_pkg::FILL_W'(lzrd_pkg::WINDOW_SIZE)),
        r_fill == $past(r_fill) + lzrd_pkg::FILL_W'(1), "ring fill count missed a write")

endmodule

>>> rtl/core/lzss_ring_decompressor.sv
// LZSS decompressor with a 1 KiB history ring: token decode and copy engine.
// Depends on lzrd_pkg, lzrd_ring and the assert header.
//
//  channel | signals                               | dir
//  --------+---------------------------------------+-----
//  in      | i_in_valid, o_in_ready, i_in_byte     | in
//  out     | o_out_valid, i_out_ready, o_out_byte, | out
//          | o_last_of_run                         |
//
// Flag and reference first-half bytes emit nothing. A literal passes
// through the emit stage into the output register. A reference emits
// length+1 bytes, one per cycle through the ring read port while the
// output register does not stall.
// The input takes a new request once the last byte sits in the output
// register; a full output register stalls the copy. Reset is synchronous, no ring sweep.
`include "lzss_ring_decompressor_assert.svh"

module lzss_ring_decompressor (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_in_byte,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_byte,
    output logic       o_last_of_run
);

    // token decode state
    logic [7:0] r_flags;
    logic [3:0] r_tokens;
    logic       r_await;
    logic [7:0] r_high;

    // copy read stage
    logic [lzrd_pkg::AW-1:0]     r_rd_addr;
    logic [lzrd_pkg::LEFT_W-1:0] r_rd_left;

    // emit stage: ring data or a literal
    logic       r_s2_valid;
    logic       r_s2_lit;
    logic       r_s2_last;
    logic [7:0] r_s2_byte;

    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_out_last;

    logic [7:0]          ring_value;
    lzrd_pkg::t_ring_req ring_req;

    logic       emit;
    logic       issue;
    logic       in_acc;
    logic [7:0] emit_byte;
    logic       is_low;
    logic       is_flag;
    logic       is_lit;

    always_comb begin
        emit      = r_s2_valid && (!r_out_valid || i_out_ready);
        emit_byte = r_s2_lit ? r_s2_byte : ring_value;
        issue     = (r_rd_left != '0) && (!r_s2_valid || emit);
        in_acc    = i_in_valid && o_in_ready;
        is_low    = r_await;
        is_flag   = !r_await && (r_tokens == 4'd0);
        is_lit    = !r_await && (r_tokens != 4'd0) && r_flags[0];

        ring_req.rd_en   = issue;
        ring_req.rd_addr = r_rd_addr;
        ring_req.wr_en   = emit;
        ring_req.wr_data = emit_byte;
    end

    assign o_in_ready    = (r_rd_left == '0) && !r_s2_valid;
    assign o_out_valid   = r_out_valid;
    assign o_out_byte    = r_out_byte;
    assign o_last_of_run = r_out_last;

    lzrd_ring u_ring (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (ring_req),
        .o_rd_value (ring_value)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags     <= '0;
            r_tokens    <= '0;
            r_await     <= 1'b0;
            r_high      <= '0;
            r_rd_left   <= '0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                if (is_low) begin
                    r_await   <= 1'b0;
                    r_tokens  <= r_tokens - 4'd1;
                    r_rd_addr <= {r_high[lzrd_pkg::AW-9:0], i_in_byte};
                    r_rd_left <= {1'b0, r_high[7:lzrd_pkg::AW-8]}
                                 + lzrd_pkg::LEFT_W'(1);
                end else if (is_flag) begin
                    r_flags  <= i_in_byte;
                    r_tokens <= lzrd_pkg::FLAG_TOKENS;
                end else if (is_lit) begin
                    r_flags  <= {1'b0, r_flags[7:1]};
                    r_tokens <= r_tokens - 4'd1;
                end else begin
                    r_flags <= {1'b0, r_flags[7:1]};
                    r_high  <= i_in_byte;
                    r_await <= 1'b1;
                end
            end else if (issue) begin
                r_rd_addr <= r_rd_addr + lzrd_pkg::AW'(1);
                r_rd_left <= r_rd_left - lzrd_pkg::LEFT_W'(1);
            end

            if (issue) begin
                r_s2_valid <= 1'b1;
                r_s2_lit   <= 1'b0;
                r_s2_last  <= (r_rd_left == lzrd_pkg::LEFT_W'(1));
            end else if (in_acc && is_lit) begin
                r_s2_valid <= 1'b1;
                r_s2_lit   <= 1'b1;
                r_s2_last  <= 1'b1;
                r_s2_byte  <= i_in_byte;
            end else if (emit) begin
                r_s2_valid <= 1'b0;
            end

            if (emit) begin
                r_out_valid <= 1'b1;
                r_out_byte  <= emit_byte;
                r_out_last  <= r_s2_last;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    `LZRD_ASSERT_ALWAYS(a_left_max, i_clk, i_rst_n,
        r_rd_left <= lzrd_pkg::LEFT_W'(64), "copy length out of range")
    `LZRD_ASSERT_ALWAYS(a_tokens_max, i_clk, i_rst_n,
        r_tokens <= lzrd_pkg::FLAG_TOKENS, "token count out of range")
    `LZRD_ASSERT_IMPLY(a_await_tok, i_clk, i_rst_n,
        r_await, r_tokens != 4'd0, "reference half pending without a token")
    `LZRD_ASSERT_IMPLY(a_last_done, i_clk, i_rst_n,
        emit && r_s2_last, r_rd_left == '0,
        "last byte emitted with copy reads outstanding")

endmodule

>>> tb/lzss_ring_decompressor_checker.sv
// Request/result checker for the LZSS ring decompressor testbench.
// Tracks accepted payload bytes, decodes them into expected output bytes,
// and compares each output. Depends on lzrd_pkg.
module lzss_ring_decompressor_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  logic [7:0] i_in_byte,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  logic [7:0] i_out_byte,
    input  logic       i_last_of_run,
    output int         o_fail_count,
    output int         o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_decoded;

    t_decoded                expected_q[$];
    logic [7:0]              history [lzrd_pkg::WINDOW_SIZE];
    logic [lzrd_pkg::AW-1:0] wr_ptr;
    logic [7:0]              flags;
    logic [3:0]              tokens;
    logic                    awaiting_lo;
    logic [7:0]              ref_hi;
    int                      fails   = 0;
    int                      pending = 0;

    assign o_fail_count = fails;
    assign o_pending    = pending;

    task automatic clear_state();
        for (int k = 0; k < lzrd_pkg::WINDOW_SIZE; k++) begin
            history[k] = (k < int'(lzrd_pkg::FILL_LIMIT)) ? lzrd_pkg::FILL_BYTE : 8'h00;
        end
        wr_ptr      = lzrd_pkg::FILL_LIMIT;
        flags       = '0;
        tokens      = '0;
        awaiting_lo = 1'b0;
        ref_hi      = '0;
        expected_q.delete();
    endtask

    task automatic emit_byte(input logic [7:0] v, input logic last);
        history[wr_ptr] = v;
        wr_ptr          = wr_ptr + lzrd_pkg::AW'(1);
        expected_q.push_back('{data: v, last: last});
    endtask

    task automatic decode_byte(input logic [7:0] b);
        logic [15:0]             word;
        int unsigned             count;
        logic [lzrd_pkg::AW-1:0] rd;
        logic                    is_literal;
        if (awaiting_lo) begin
            word  = {ref_hi, b};
            count = 32'(word[15:lzrd_pkg::AW]) + 32'd1;
            rd    = word[lzrd_pkg::AW-1:0];
            for (int k = 0; k < count; k++) begin
                emit_byte(history[rd], k == count - 1);
                rd = rd + lzrd_pkg::AW'(1);
            end
            awaiting_lo = 1'b0;
            tokens      = tokens - 4'd1;
        end else if (tokens == 4'd0) begin
            flags  = b;
            tokens = lzrd_pkg::FLAG_TOKENS;
        end else begin
            is_literal = flags[0];
            flags      = flags >> 1;
            if (is_literal) begin
                tokens = tokens - 4'd1;
                emit_byte(b, 1'b1);
            end else begin
                ref_hi      = b;
                awaiting_lo = 1'b1;
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_decoded want;
        if (!i_rst_n) begin
            clear_state();
        end else begin
            if (i_in_valid && i_in_ready) begin
                decode_byte(i_in_byte);
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_q.size() == 0) begin
                    $error("unexpected result: out_byte %02h last_of_run %0b",
                           i_out_byte, i_last_of_run);
                    fails++;
                end else begin
                    want = expected_q.pop_front();
                    if (want.data !== i_out_byte) begin
                        $error("out_byte mismatch: expected %02h, actual %02h",
                               want.data, i_out_byte);
                        fails++;
                    end
                    if (want.last !== i_last_of_run) begin
                        $error("last_of_run mismatch: expected %0b, actual %0b",
                               want.last, i_last_of_run);
                        fails++;
                    end
                end
            end
        end
        pending = expected_q.size();
    end

endmodule

>>> tb/lzss_ring_decompressor_tb.sv
// Top testbench for lzss_ring_decompressor: clock, reset, payload stimulus
// and output stalls. Depends on lzrd_pkg, the RTL and the checker module.
module lzss_ring_decompressor_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEM_TARGET  = 310;
    localparam int NOISE_START  = 280;
    localparam int DRAIN_CYCLES = 100;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_in_valid  = 1'b0;
    logic       o_in_ready;
    logic [7:0] i_in_byte   = 8'h00;
    logic       o_out_valid;
    logic       i_out_ready = 1'b0;
    logic [7:0] o_out_byte;
    logic       o_last_of_run;

    int                      fail_count;
    int                      pending;
    int                      sent_count = 0;
    int                      burst_left = 0;
    int                      stall_mode = 0;
    int                      stall_hold = 0;
    logic [lzrd_pkg::AW-1:0] approx_wp  = lzrd_pkg::FILL_LIMIT;

    lzss_ring_decompressor dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_in_byte     (i_in_byte),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_byte    (o_out_byte),
        .o_last_of_run (o_last_of_run)
    );

    lzss_ring_decompressor_checker checker_inst (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_ready    (o_in_ready),
        .i_in_byte     (i_in_byte),
        .i_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .i_out_byte    (o_out_byte),
        .i_last_of_run (o_last_of_run),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // output stalls: free-running, random, or mostly blocked, switching now and then
    always @(posedge i_clk) begin
        if (stall_hold == 0) begin
            stall_mode <= $urandom_range(0, 2);
            stall_hold <= $urandom_range(16, 160);
        end else begin
            stall_hold <= stall_hold - 1;
        end
        case (stall_mode)
            0: i_out_ready <= 1'b1;
            1: i_out_ready <= 1'($urandom_range(0, 1));
            default: i_out_ready <= ($urandom_range(0, 4) == 0);
        endcase
    end

    task automatic push_byte(input logic [7:0] b);
        int gap;
        i_in_valid <= 1'b1;
        i_in_byte  <= b;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sent_count++;
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic push_ref(input logic [5:0] len_m1, input logic [lzrd_pkg::AW-1:0] idx);
        push_byte({len_m1, idx[lzrd_pkg::AW-1:8]});
        push_byte(idx[7:0]);
        approx_wp = approx_wp + lzrd_pkg::AW'(len_m1) + lzrd_pkg::AW'(1);
    endtask

    // one flag byte and its eight tokens with random content
    task automatic push_group();
        logic [7:0]              flag;
        logic [5:0]              len_m1;
        logic [lzrd_pkg::AW-1:0] idx;
        flag = 8'($urandom);
        push_byte(flag);
        for (int t = 0; t < 8; t++) begin
            if (flag[t]) begin
                push_byte(8'($urandom));
                approx_wp = approx_wp + lzrd_pkg::AW'(1);
            end else begin
                len_m1 = ($urandom_range(0, 5) == 0) ? 6'($urandom_range(0, 63))
                                                     : 6'($urandom_range(0, 5));
                idx = ($urandom_range(0, 1) == 0)
                    ? lzrd_pkg::AW'($urandom)
                    : approx_wp - lzrd_pkg::AW'($urandom_range(1, 16));
                push_ref(len_m1, idx);
            end
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // literal, max-length ref wrapping the read index, single-byte ref to that copy's last byte,
        // ref into the start of the written area, then literals
        push_byte(8'b1111_0001);
        push_byte(8'h00);
        push_byte(8'hFF);
        push_byte(8'hFF);
        push_byte(8'h00);
        push_byte(8'h00);
        push_byte(8'h07);
        push_byte(8'hC0);
        push_byte(8'hFF);
        push_byte(8'hAA);
        push_byte(8'h55);
        push_byte(8'h80);
        // write pointer has wrapped to 8: copy that overlaps its own output
        push_byte(8'hFE);
        push_byte(8'h4C);
        push_byte(8'h07);
        for (int k = 0; k < 7; k++) push_byte(8'($urandom));
        approx_wp = lzrd_pkg::AW'(35);

        while (sent_count < NOISE_START) push_group();
        while (sent_count < ITEM_TARGET) push_byte(8'($urandom));
        i_in_valid <= 1'b0;

        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
